@@ design/bmpascii_pkg.sv @@
package bmpascii_pkg;

  // Largest accepted image width or height, in pixels
  localparam int unsigned MAX_DIM = 4096;
  // Pixel counters hold 0..MAX_DIM
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  localparam int unsigned SYM_W = 7;
  localparam int unsigned POS_W = 12;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_DIM   = 2'd2;

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_M = 8'h4d;

  // Header byte positions of the little-endian words
  localparam logic [4:0] OFFSET_POS = 5'd10;
  localparam logic [4:0] WIDTH_POS  = 5'd18;
  localparam logic [4:0] HEIGHT_POS = 5'd22;
  localparam logic [4:0] HEADER_END = 5'd25;

  // Luma weights, unsigned Q0.16
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam int unsigned LUMA_BAND = 20;
  localparam int unsigned RAMP_LEN  = 13;

  localparam logic [SYM_W-1:0] RAMP [RAMP_LEN] = '{
    7'h40, 7'h24, 7'h23, 7'h2a, 7'h21, 7'h3d, 7'h3b,
    7'h3a, 7'h7e, 7'h2d, 7'h2c, 7'h2e, 7'h20
  };

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } byte_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_column;
    logic             last_pixel;
    logic [1:0]       fault;
  } char_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_PIXELS = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  // Band of 20 luma levels -> ramp character
  function automatic logic [SYM_W-1:0] luma_symbol(input logic [7:0] luma);
    logic [3:0] idx;
    idx = '0;
    for (int k = 1; k < RAMP_LEN; k++) begin
      if (luma >= 8'(k * LUMA_BAND)) idx = 4'(k);
    end
    return RAMP[idx];
  endfunction

endpackage

@@ design/bmp_to_ascii_art_decoder.sv @@
// Decodes a 24-bit BMP file fed one byte per word into ASCII-art characters,
// one result word per pixel (top-down row, column, last flag) or one error
// word for a bad magic or out-of-range dimensions. A byte is taken every
// cycle; its result appears in the output register on the next cycle. The
// byte side stalls only while a held result is itself stalled. The cycle is
// bounded by the three constant-weight luma multiplies, their sum and the
// ramp lookup, all in one pass from the accepted byte to the result register.
module bmp_to_ascii_art_decoder import bmpascii_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_stall,
  input  byte_t byte_data,
  output logic  char_valid,
  input  logic  char_stall,
  output char_t char_data
);

  phase_t           phase, phase_next;
  logic [31:0]      position, position_next;
  logic [31:0]      data_offset, data_offset_next;
  logic [31:0]      image_width, image_width_next;
  logic [31:0]      image_height, image_height_next;
  logic [1:0]       color_index, color_index_next;
  logic [7:0]       blue_hold, blue_hold_next;
  logic [7:0]       green_hold, green_hold_next;
  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic [1:0]       padding_left, padding_left_next;

  logic        accept;
  logic        has_result;
  char_t       result;
  logic [7:0]  b;
  logic [4:0]  hdr_pos;
  logic [23:0] luma_sum;
  logic [31:0] row_td;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic        pixel_step;

  assign byte_stall = char_valid && char_stall;
  assign accept     = byte_valid && !byte_stall;
  assign b          = byte_data.file_byte;

  assign luma_sum = 24'(W_RED) * 24'(b) + 24'(W_GREEN) * 24'(green_hold)
                  + 24'(W_BLUE) * 24'(blue_hold);

  always_comb begin
    // start of file wipes the parse state before this byte is handled
    if (byte_data.start_of_file) begin
      phase_next        = PH_HEADER;
      position_next     = '0;
      data_offset_next  = '0;
      image_width_next  = '0;
      image_height_next = '0;
      color_index_next  = '0;
      column_count_next = '0;
      row_count_next    = '0;
      padding_left_next = '0;
    end else begin
      phase_next        = phase;
      position_next     = position;
      data_offset_next  = data_offset;
      image_width_next  = image_width;
      image_height_next = image_height;
      color_index_next  = color_index;
      column_count_next = column_count;
      row_count_next    = row_count;
      padding_left_next = padding_left;
    end
    blue_hold_next  = blue_hold;
    green_hold_next = green_hold;
    has_result      = 1'b0;
    result          = '0;
    pixel_step      = 1'b0;
    hdr_pos         = position_next[4:0];
    col_inc         = column_count_next + 1'b1;
    row_inc         = row_count_next + 1'b1;
    row_td          = image_height_next - 32'd1 - 32'(row_count_next);

    unique case (phase_next)
      PH_HEADER: begin
        // header positions never pass 25, low bits suffice
        position_next = position_next + 32'd1;
        if ((hdr_pos == 5'd0 && b != MAGIC_B) || (hdr_pos == 5'd1 && b != MAGIC_M)) begin
          phase_next   = PH_HALT;
          has_result   = 1'b1;
          result.fault = ERR_MAGIC;
        end else begin
          case (hdr_pos)
            OFFSET_POS:         data_offset_next[7:0]    = b;
            OFFSET_POS + 5'd1:  data_offset_next[15:8]   = b;
            OFFSET_POS + 5'd2:  data_offset_next[23:16]  = b;
            OFFSET_POS + 5'd3:  data_offset_next[31:24]  = b;
            WIDTH_POS:          image_width_next[7:0]    = b;
            WIDTH_POS + 5'd1:   image_width_next[15:8]   = b;
            WIDTH_POS + 5'd2:   image_width_next[23:16]  = b;
            WIDTH_POS + 5'd3:   image_width_next[31:24]  = b;
            HEIGHT_POS:         image_height_next[7:0]   = b;
            HEIGHT_POS + 5'd1:  image_height_next[15:8]  = b;
            HEIGHT_POS + 5'd2:  image_height_next[23:16] = b;
            HEIGHT_POS + 5'd3:  image_height_next[31:24] = b;
            default: ;
          endcase
          if (hdr_pos == HEADER_END) begin
            if (image_width_next == '0 || image_width_next > 32'(MAX_DIM) ||
                image_height_next == '0 || image_height_next > 32'(MAX_DIM)) begin
              phase_next   = PH_HALT;
              has_result   = 1'b1;
              result.fault = ERR_DIM;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (position_next < data_offset_next) begin
          position_next = position_next + 32'd1;
        end else begin
          phase_next = PH_PIXELS;
          pixel_step = 1'b1;
        end
      end
      PH_PIXELS: pixel_step = 1'b1;
      PH_PAD: begin
        if (padding_left_next != '0) padding_left_next = padding_left_next - 2'd1;
        if (padding_left_next == '0) phase_next = PH_PIXELS;
      end
      PH_IDLE, PH_HALT: ;
      default: ;
    endcase

    if (pixel_step) begin
      case (color_index_next)
        2'd0: begin
          blue_hold_next   = b;
          color_index_next = 2'd1;
        end
        2'd1: begin
          green_hold_next  = b;
          color_index_next = 2'd2;
        end
        default: begin
          // red byte completes the pixel
          color_index_next    = 2'd0;
          has_result          = 1'b1;
          result.symbol       = luma_symbol(luma_sum[23:16]);
          result.pixel_row    = row_td[POS_W-1:0];
          result.pixel_column = POS_W'(32'(column_count_next));
          result.last_pixel   = (row_inc == image_height_next[DIM_W-1:0]) &&
                                (col_inc == image_width_next[DIM_W-1:0]);
          result.fault        = ERR_NONE;
          if (col_inc == image_width_next[DIM_W-1:0]) begin
            column_count_next = '0;
            row_count_next    = row_inc;
            if (row_inc == image_height_next[DIM_W-1:0]) begin
              phase_next = PH_HALT;
            end else begin
              padding_left_next = image_width_next[1:0];
              phase_next = (image_width_next[1:0] != 2'd0) ? PH_PAD : PH_PIXELS;
            end
          end else begin
            column_count_next = col_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      position     <= '0;
      data_offset  <= '0;
      image_width  <= '0;
      image_height <= '0;
      color_index  <= '0;
      blue_hold    <= '0;
      green_hold   <= '0;
      column_count <= '0;
      row_count    <= '0;
      padding_left <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      position     <= position_next;
      data_offset  <= data_offset_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      color_index  <= color_index_next;
      blue_hold    <= blue_hold_next;
      green_hold   <= green_hold_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      padding_left <= padding_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!byte_stall) begin
      char_valid <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) char_data <= result;
  end

endmodule

@@ design/bmpascii_checker.sv @@
module bmpascii_checker import bmpascii_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  byte_stall,
  input logic  char_valid,
  input logic  char_stall,
  input char_t char_data
);

  // held result word stays put
  assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_data))
    else $error("stalled result word changed or dropped");

  // byte side waits only on a blocked result register
  assert property (@(posedge clk) disable iff (rst)
    byte_stall == (char_valid && char_stall))
    else $error("byte stall does not follow result back-pressure");

  assert property (@(posedge clk) disable iff (rst)
    char_valid && char_data.fault != ERR_NONE |->
      char_data.symbol == '0 && char_data.pixel_row == '0 &&
      char_data.pixel_column == '0 && !char_data.last_pixel)
    else $error("error word carries pixel fields");

  assert property (@(posedge clk) disable iff (rst)
    char_valid && char_data.fault == ERR_NONE |-> char_data.symbol >= 7'h20)
    else $error("pixel word without a printable symbol");

  assert property (@(posedge clk) disable iff (rst)
    char_valid && char_data.fault != ERR_NONE && char_data.fault != ERR_MAGIC
      |-> char_data.fault == ERR_DIM)
    else $error("unknown error code");

endmodule

bind bmp_to_ascii_art_decoder bmpascii_checker u_bmpascii_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_stall (byte_stall),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_data  (char_data)
);

@@ dv/bmp_char_checker.sv @@
`timescale 1ns / 100ps

module bmp_char_checker import bmpascii_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  input  logic  byte_stall,
  input  byte_t byte_data,
  input  logic  char_valid,
  input  logic  char_stall,
  input  char_t char_data,
  output int    fails,
  output int    pending
);

  // darkest to lightest, one character per band of 20 luma levels
  localparam logic [7:0] SHADES [RAMP_LEN] = '{
    "@", "$", "#", "*", "!", "=", ";", ":", "~", "-", ",", ".", " "
  };

  phase_t      stage;
  logic [31:0] file_pos;
  logic [31:0] pix_base;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [31:0] col_cnt;
  logic [31:0] row_cnt;
  logic [1:0]  chan;
  logic [1:0]  pad_cnt;
  logic [7:0]  blu;
  logic [7:0]  grn;
  char_t       due_chars [$];

  initial begin
    fails = 0;
    pending = 0;
  end

  function automatic void clear_state();
    stage = PH_IDLE;
    file_pos = '0;
    pix_base = '0;
    img_w = '0;
    img_h = '0;
    col_cnt = '0;
    row_cnt = '0;
    chan = '0;
    pad_cnt = '0;
    blu = '0;
    grn = '0;
  endfunction

  function automatic void bump_pos();
    if (file_pos != '1) file_pos++;
  endfunction

  // One colour byte; the red byte completes a pixel and yields a word
  function automatic bit shade_pixel(input logic [7:0] b, output char_t res);
    logic [31:0] luma;
    res = '0;
    if (chan == 2'd0) begin
      blu = b;
      chan = 2'd1;
      return 1'b0;
    end
    if (chan == 2'd1) begin
      grn = b;
      chan = 2'd2;
      return 1'b0;
    end
    chan = 2'd0;
    luma = (32'(W_RED) * 32'(b) + 32'(W_GREEN) * 32'(grn) + 32'(W_BLUE) * 32'(blu)) >> 16;
    res.symbol = SHADES[4'(luma / LUMA_BAND)][SYM_W-1:0];
    res.pixel_row = POS_W'(img_h - 32'd1 - row_cnt);
    res.pixel_column = POS_W'(col_cnt);
    res.last_pixel = (row_cnt + 32'd1 == img_h) && (col_cnt + 32'd1 == img_w);
    res.fault = ERR_NONE;
    col_cnt++;
    if (col_cnt >= img_w) begin
      col_cnt = '0;
      row_cnt++;
      if (row_cnt >= img_h) begin
        stage = PH_HALT;
      end else begin
        pad_cnt = img_w[1:0];
        stage = (pad_cnt != 2'd0) ? PH_PAD : PH_PIXELS;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input byte_t w, output char_t res);
    logic [31:0] p;
    res = '0;
    if (w.start_of_file) begin
      clear_state();
      stage = PH_HEADER;
    end
    case (stage)
      PH_HEADER: begin
        p = file_pos;
        bump_pos();
        if ((p == 32'd0 && w.file_byte != MAGIC_B) || (p == 32'd1 && w.file_byte != MAGIC_M)) begin
          stage = PH_HALT;
          res.fault = ERR_MAGIC;
          return 1'b1;
        end
        if (p >= OFFSET_POS && p <= OFFSET_POS + 3)
          pix_base |= 32'(w.file_byte) << (8 * (p - OFFSET_POS));
        else if (p >= WIDTH_POS && p <= WIDTH_POS + 3)
          img_w |= 32'(w.file_byte) << (8 * (p - WIDTH_POS));
        else if (p >= HEIGHT_POS && p <= HEIGHT_POS + 3)
          img_h |= 32'(w.file_byte) << (8 * (p - HEIGHT_POS));
        if (p == HEADER_END) begin
          if (img_w < 1 || img_w > MAX_DIM || img_h < 1 || img_h > MAX_DIM) begin
            stage = PH_HALT;
            res.fault = ERR_DIM;
            return 1'b1;
          end
          stage = PH_SKIP;
        end
        return 1'b0;
      end
      PH_SKIP: begin
        if (file_pos < pix_base) begin
          bump_pos();
          return 1'b0;
        end
        // first pixel byte ends the skip in the same step
        stage = PH_PIXELS;
        return shade_pixel(w.file_byte, res);
      end
      PH_PIXELS: return shade_pixel(w.file_byte, res);
      PH_PAD: begin
        if (pad_cnt != 2'd0) pad_cnt--;
        if (pad_cnt == 2'd0) stage = PH_PIXELS;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_field(input string name, input int unsigned want_v, input int unsigned got_v);
    fails++;
    $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want_v, got_v);
  endtask

  always @(posedge clk) begin
    char_t want;
    char_t word;
    if (rst) begin
      clear_state();
      due_chars.delete();
    end else begin
      if (char_valid && !char_stall) begin
        if (due_chars.size() == 0) begin
          fails++;
          $display("%0t: unexpected word sym %0h row %0d col %0d last %0b err %0d", $time,
                   char_data.symbol, char_data.pixel_row, char_data.pixel_column,
                   char_data.last_pixel, char_data.fault);
        end else begin
          want = due_chars.pop_front();
          if (char_data.symbol !== want.symbol)
            flag_field("symbol", want.symbol, char_data.symbol);
          if (char_data.pixel_row !== want.pixel_row)
            flag_field("pixel_row", want.pixel_row, char_data.pixel_row);
          if (char_data.pixel_column !== want.pixel_column)
            flag_field("pixel_column", want.pixel_column, char_data.pixel_column);
          if (char_data.last_pixel !== want.last_pixel)
            flag_field("last_pixel", want.last_pixel, char_data.last_pixel);
          if (char_data.fault !== want.fault)
            flag_field("fault", want.fault, char_data.fault);
        end
      end
      if (byte_valid && !byte_stall) begin
        if (decode_byte(byte_data, word)) due_chars.push_back(word);
      end
    end
    pending <= due_chars.size();
  end

endmodule

@@ dv/tb_bmp_to_ascii_art_decoder.sv @@
`timescale 1ns / 100ps

module tb_bmp_to_ascii_art_decoder;
  import bmpascii_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_BYTES = 550;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  byte_valid = 1'b0;
  logic  byte_stall;
  byte_t byte_data = '0;
  logic  char_valid;
  logic  char_stall = 1'b0;
  char_t char_data;
  int    fails;
  int    pending;

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned random_sent = 0;
  logic [7:0]  file_q [$];

  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  bmp_to_ascii_art_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

  bmp_char_checker chk (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .fails      (fails),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bmp_to_ascii_art_decoder: FAIL");
      $finish;
    end
  end

  // receiver back-pressure: a new mode every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE:  char_stall <= 1'b0;
      RX_LIGHT: char_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: char_stall <= ($urandom_range(0, 1) == 1);
      default:  char_stall <= ((rx_tick % 16) < 11);
    endcase
  end

  task automatic send_word(input logic [7:0] b, input logic sof);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data <= '{file_byte: b, start_of_file: sof};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    byte_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic feed_file();
    foreach (file_q[i]) send_word(file_q[i], i == 0);
  endtask

  function automatic void put_le32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q.push_back(v[8*k +: 8]);
  endfunction

  function automatic void build_header(input logic [31:0] w, h, ofs);
    file_q.delete();
    file_q.push_back(MAGIC_B);
    file_q.push_back(MAGIC_M);
    repeat (8) file_q.push_back(8'($urandom));
    put_le32(ofs);
    repeat (4) file_q.push_back(8'($urandom));
    put_le32(w);
    put_le32(h);
  endfunction

  function automatic void build_image(input int unsigned w, h, ofs, tail);
    logic [7:0] g;
    build_header(w, h, ofs);
    for (int unsigned k = HEADER_END + 1; k < ofs; k++) file_q.push_back(8'($urandom));
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case ($urandom_range(0, 7))
          0: repeat (3) file_q.push_back(8'h00);
          1: repeat (3) file_q.push_back(8'hff);
          2: begin
            // grey spreads luma evenly over the ramp
            g = 8'($urandom);
            repeat (3) file_q.push_back(g);
          end
          default: repeat (3) file_q.push_back(8'($urandom));
        endcase
      end
      repeat (w % 4) file_q.push_back(8'($urandom));
    end
    repeat (tail) file_q.push_back(8'($urandom));
  endfunction

  initial begin
    int unsigned pick, w, h, ofs, n, good, bad;
    logic [7:0] bad_byte;
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nothing started yet: ignored
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    // wrong first magic byte, then the rest ignored
    send_word(8'h00, 1'b1);
    send_word(MAGIC_B, 1'b0);
    // wrong second magic byte
    send_word(MAGIC_B, 1'b1);
    send_word(8'hff, 1'b0);
    // header cut short by a fresh start
    send_word(MAGIC_B, 1'b1);
    send_word(MAGIC_M, 1'b0);
    send_word(8'ha5, 1'b0);
    send_word(8'h5a, 1'b0);
    settle();

    while (random_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 13 || pick > 16) begin
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 13) : $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
          0, 1: ofs = $urandom_range(0, HEADER_END + 1);
          2:    ofs = 0;
          3, 4: ofs = $urandom_range(27, 40);
          5:    ofs = $urandom_range(256, 300);
          default: ofs = 54;
        endcase
        build_image(w, h, ofs, $urandom_range(0, 3));
        // broken file: the next start cuts it off
        if (pick > 16) begin
          n = $urandom_range(1, file_q.size() - 1);
          while (file_q.size() > n) file_q.delete(file_q.size() - 1);
        end
      end else if (pick < 15) begin
        good = $urandom_range(1, MAX_DIM);
        case ($urandom_range(0, 4))
          0: bad = 0;
          1: bad = MAX_DIM + 1;
          2: bad = $urandom_range(MAX_DIM + 2, 65535);
          3: bad = 32'hffff_ffff;
          default: bad = $urandom | 32'h8000_0000;
        endcase
        case ($urandom_range(0, 2))
          0: build_header(bad, good, 54);
          1: build_header(good, bad, 54);
          default: build_header(bad, bad, 54);
        endcase
        repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
      end else begin
        build_header(1, 1, 0);
        bad_byte = 8'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          if (bad_byte == MAGIC_B) bad_byte ^= 8'h01;
          file_q[0] = bad_byte;
        end else begin
          if (bad_byte == MAGIC_M) bad_byte ^= 8'h01;
          file_q[1] = bad_byte;
        end
        n = $urandom_range(2, 8);
        while (file_q.size() > n) file_q.delete(file_q.size() - 1);
      end
      feed_file();
      random_sent += file_q.size();
      if (!paused && random_sent >= RANDOM_BYTES / 2) begin
        settle();
        paused = 1'b1;
      end
    end

    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb_bmp_to_ascii_art_decoder: PASS");
    end else begin
      $display("tb_bmp_to_ascii_art_decoder: FAIL");
    end
    $finish;
  end

endmodule
